>>> hdl/twelve_hour_clock_lcd_updater_unit_defines.svh
// Assertion macros for the twelve-hour clock display updater checker.
`ifndef TWELVE_HOUR_CLOCK_LCD_UPDATER_UNIT_DEFINES_SVH
`define TWELVE_HOUR_CLOCK_LCD_UPDATER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define THCLU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define THCLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/thclu_pkg.sv
// Shared types, constants and digit helper for the twelve-hour clock display updater.
package thclu_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] TICK_LIMIT_RESET    = 8'd100;
    localparam logic [6:0] HOUR_COLUMN_RESET   = 7'd7;
    localparam logic [6:0] MINUTE_COLUMN_RESET = 7'd10;
    localparam logic [6:0] SECOND_COLUMN_RESET = 7'd13;

    localparam logic [5:0] MAX_MIN_SEC = 6'd59;
    localparam logic [3:0] MAX_HOUR    = 4'd12;
    localparam logic [3:0] MIN_HOUR    = 4'd1;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    // Register indexes on the config port
    localparam logic [1:0] REG_TICK_LIMIT    = 2'd0;
    localparam logic [1:0] REG_HOUR_COLUMN   = 2'd1;
    localparam logic [1:0] REG_MINUTE_COLUMN = 2'd2;
    localparam logic [1:0] REG_SECOND_COLUMN = 2'd3;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    typedef enum logic [1:0] {
        PHASE_COUNT  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_MINUTE = 2'd2,
        PHASE_HOUR   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        BEAT_CMD  = 2'd0,
        BEAT_TENS = 2'd1,
        BEAT_ONES = 2'd2
    } beat_t;

    typedef struct packed {
        logic       func;
        logic [3:0] set_hour;
        logic [5:0] set_minute;
        logic [5:0] set_second;
    } in_item_t;

    typedef struct packed {
        logic       register_select;
        logic [7:0] lcd_byte;
        logic       last_write;
    } out_item_t;

    typedef struct packed {
        logic [7:0] tick_limit;
        logic [6:0] hour_column;
        logic [6:0] minute_column;
        logic [6:0] second_column;
    } cfg_t;

    // One field update queued between front and back
    typedef struct packed {
        logic [6:0] column;
        logic [7:0] tens;
        logic [7:0] ones;
    } show_t;

    typedef struct packed {
        logic [7:0] tens;
        logic [7:0] ones;
    } digits_t;

    function automatic digits_t to_digits(logic [5:0] v);
        digits_t    d;
        logic [2:0] t;
        logic [5:0] r;
        if (v >= 6'd60) begin
            t = 3'd6; r = v - 6'd60;
        end else if (v >= 6'd50) begin
            t = 3'd5; r = v - 6'd50;
        end else if (v >= 6'd40) begin
            t = 3'd4; r = v - 6'd40;
        end else if (v >= 6'd30) begin
            t = 3'd3; r = v - 6'd30;
        end else if (v >= 6'd20) begin
            t = 3'd2; r = v - 6'd20;
        end else if (v >= 6'd10) begin
            t = 3'd1; r = v - 6'd10;
        end else begin
            t = 3'd0; r = v;
        end
        d.tens = ASCII_ZERO | {5'd0, t};
        d.ones = ASCII_ZERO | {4'd0, r[3:0]};
        return d;
    endfunction

endpackage

>>> hdl/thclu_front.sv
// Front end: accepts tick and load beats, keeps the time, queues field updates.
module thclu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  thclu_pkg::in_item_t in_data,
    input  thclu_pkg::cfg_t     cfg,
    input  logic                queue_full,
    output logic                push,
    output thclu_pkg::show_t    push_data
);

    logic [7:0]        prescale_reg, prescale_next;
    logic [5:0]        seconds_reg, seconds_next;
    logic [5:0]        minutes_reg, minutes_next;
    logic [3:0]        hours_reg, hours_next;
    thclu_pkg::phase_t phase_reg, phase_next;

    logic              accept;
    logic              is_tick;
    thclu_pkg::digits_t dig;
    logic [5:0]        show_value;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign is_tick  = (in_data.func == thclu_pkg::FUNC_TICK);

    always_comb
    begin
        prescale_next = prescale_reg;
        seconds_next  = seconds_reg;
        minutes_next  = minutes_reg;
        hours_next    = hours_reg;
        phase_next    = phase_reg;
        push          = 1'b0;

        if (accept && !is_tick) begin
            if (in_data.set_hour < thclu_pkg::MIN_HOUR)
                hours_next = thclu_pkg::MIN_HOUR;
            else if (in_data.set_hour > thclu_pkg::MAX_HOUR)
                hours_next = thclu_pkg::MAX_HOUR;
            else
                hours_next = in_data.set_hour;
            minutes_next = (in_data.set_minute > thclu_pkg::MAX_MIN_SEC) ?
                           thclu_pkg::MAX_MIN_SEC : in_data.set_minute;
            seconds_next = (in_data.set_second > thclu_pkg::MAX_MIN_SEC) ?
                           thclu_pkg::MAX_MIN_SEC : in_data.set_second;
        end else if (accept) begin
            prescale_next = (prescale_reg < cfg.tick_limit) ? prescale_reg + 8'd1 : 8'd0;
            unique case (phase_reg)
                thclu_pkg::PHASE_COUNT:
                begin
                    if (prescale_next == cfg.tick_limit) begin
                        if (seconds_reg < thclu_pkg::MAX_MIN_SEC) begin
                            seconds_next = seconds_reg + 6'd1;
                            phase_next   = thclu_pkg::PHASE_SECOND;
                        end else if (minutes_reg < thclu_pkg::MAX_MIN_SEC) begin
                            seconds_next = 6'd0;
                            minutes_next = minutes_reg + 6'd1;
                            phase_next   = thclu_pkg::PHASE_MINUTE;
                        end else begin
                            seconds_next = 6'd0;
                            minutes_next = 6'd0;
                            hours_next   = (hours_reg >= thclu_pkg::MAX_HOUR) ?
                                           thclu_pkg::MIN_HOUR : hours_reg + 4'd1;
                            phase_next   = thclu_pkg::PHASE_HOUR;
                        end
                    end
                end
                thclu_pkg::PHASE_HOUR:
                begin
                    push       = 1'b1;
                    phase_next = thclu_pkg::PHASE_MINUTE;
                end
                thclu_pkg::PHASE_MINUTE:
                begin
                    push       = 1'b1;
                    phase_next = thclu_pkg::PHASE_SECOND;
                end
                thclu_pkg::PHASE_SECOND:
                begin
                    push       = 1'b1;
                    phase_next = thclu_pkg::PHASE_COUNT;
                end
            endcase
        end
    end

    // Field to show follows the phase; values already reflect earlier loads
    always_comb
    begin
        unique case (phase_reg)
            thclu_pkg::PHASE_HOUR:
            begin
                show_value       = {2'd0, hours_reg};
                push_data.column = cfg.hour_column;
            end
            thclu_pkg::PHASE_MINUTE:
            begin
                show_value       = minutes_reg;
                push_data.column = cfg.minute_column;
            end
            default:
            begin
                show_value       = seconds_reg;
                push_data.column = cfg.second_column;
            end
        endcase
        dig            = thclu_pkg::to_digits(show_value);
        push_data.ones = dig.ones;
        // blank leading zero of the hour only
        if (phase_reg == thclu_pkg::PHASE_HOUR && dig.tens == thclu_pkg::ASCII_ZERO)
            push_data.tens = thclu_pkg::ASCII_SPACE;
        else
            push_data.tens = dig.tens;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prescale_reg <= 8'd0;
            seconds_reg  <= 6'd0;
            minutes_reg  <= 6'd0;
            hours_reg    <= thclu_pkg::MAX_HOUR;
            phase_reg    <= thclu_pkg::PHASE_COUNT;
        end else begin
            prescale_reg <= prescale_next;
            seconds_reg  <= seconds_next;
            minutes_reg  <= minutes_next;
            hours_reg    <= hours_next;
            phase_reg    <= phase_next;
        end
    end

endmodule

>>> hdl/thclu_queue.sv
// Small FIFO of pending field updates between front and back.
module thclu_queue #(
    parameter int DEPTH = thclu_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  thclu_pkg::show_t push_data,
    input  logic             pop,
    output thclu_pkg::show_t head,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    thclu_pkg::show_t entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/thclu_back.sv
// Back end: turns each queued field update into three display write beats.
module thclu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  thclu_pkg::show_t     head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output thclu_pkg::out_item_t out_data
);

    thclu_pkg::beat_t     beat_reg, beat_next;
    logic                 valid_reg, valid_next;
    thclu_pkg::out_item_t data_reg, data_next;
    logic                 load;

    assign load      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                unique case (beat_reg)
                    thclu_pkg::BEAT_CMD:
                    begin
                        data_next.register_select = thclu_pkg::RS_COMMAND;
                        data_next.lcd_byte        = {1'b1, head.column};
                        data_next.last_write      = 1'b0;
                        beat_next                 = thclu_pkg::BEAT_TENS;
                    end
                    thclu_pkg::BEAT_TENS:
                    begin
                        data_next.register_select = thclu_pkg::RS_DATA;
                        data_next.lcd_byte        = head.tens;
                        data_next.last_write      = 1'b0;
                        beat_next                 = thclu_pkg::BEAT_ONES;
                    end
                    thclu_pkg::BEAT_ONES:
                    begin
                        data_next.register_select = thclu_pkg::RS_DATA;
                        data_next.lcd_byte        = head.ones;
                        data_next.last_write      = 1'b1;
                        beat_next                 = thclu_pkg::BEAT_CMD;
                        pop                       = 1'b1;
                    end
                    default:
                    begin
                        beat_next = thclu_pkg::BEAT_CMD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            beat_reg  <= thclu_pkg::BEAT_CMD;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

>>> hdl/twelve_hour_clock_lcd_updater_unit.sv
// Top level of the twelve-hour clock display updater: config port, front, queue, back.
//
//  channel   dir  handshake              beat
//  in        in   in_valid / in_stall    tick or load time (in_item_t)
//  out       out  out_valid / out_stall  one display write (out_item_t)
//  config    in   APB psel/penable       tick_limit and three columns
//
// One input beat per cycle while the update queue has room.
// A field update leaves as three output beats, back to back while out_stall is low,
// from the back end's output register; the back end sets the rate.
// in_stall rises whenever the queue is full; a cascade pushes one update per
// tick but each update drains over three beats, so it fills even with no out stall.
// Reset restores the time to 12:00:00 and the registers to their defaults.
module twelve_hour_clock_lcd_updater_unit #(
    parameter int QUEUE_DEPTH = thclu_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  thclu_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output thclu_pkg::out_item_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    thclu_pkg::cfg_t  cfg_reg, cfg_next;
    logic             wr_en;
    logic             push, pop, q_empty, q_full;
    thclu_pkg::show_t push_data, head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                thclu_pkg::REG_TICK_LIMIT:    cfg_next.tick_limit    = pwdata[7:0];
                thclu_pkg::REG_HOUR_COLUMN:   cfg_next.hour_column   = pwdata[6:0];
                thclu_pkg::REG_MINUTE_COLUMN: cfg_next.minute_column = pwdata[6:0];
                thclu_pkg::REG_SECOND_COLUMN: cfg_next.second_column = pwdata[6:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            thclu_pkg::REG_TICK_LIMIT:    prdata = {24'd0, cfg_reg.tick_limit};
            thclu_pkg::REG_HOUR_COLUMN:   prdata = {25'd0, cfg_reg.hour_column};
            thclu_pkg::REG_MINUTE_COLUMN: prdata = {25'd0, cfg_reg.minute_column};
            thclu_pkg::REG_SECOND_COLUMN: prdata = {25'd0, cfg_reg.second_column};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.tick_limit    <= thclu_pkg::TICK_LIMIT_RESET;
            cfg_reg.hour_column   <= thclu_pkg::HOUR_COLUMN_RESET;
            cfg_reg.minute_column <= thclu_pkg::MINUTE_COLUMN_RESET;
            cfg_reg.second_column <= thclu_pkg::SECOND_COLUMN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    thclu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .queue_full (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    thclu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    thclu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> hdl/thclu_checker.sv
// Port-level assertions for the twelve-hour clock display updater, bound to the top level.
`include "twelve_hour_clock_lcd_updater_unit_defines.svh"

module thclu_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input thclu_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_stall,
    input thclu_pkg::out_item_t out_data
);

    logic in_wait;
    logic out_wait;
    logic out_take;
    logic out_cmd;

    assign in_wait  = in_valid && in_stall;
    assign out_wait = out_valid && out_stall;
    assign out_take = out_valid && !out_stall;
    assign out_cmd  = out_valid && (out_data.register_select == thclu_pkg::RS_COMMAND);

    `THCLU_ASSERT_NEXT(a_in_held, in_wait, in_valid && $stable(in_data), "in beat changed")

    `THCLU_ASSERT_NEXT(a_out_valid_held, out_wait, out_valid, "out beat dropped under stall")

    `THCLU_ASSERT_NEXT(a_out_data_held, out_wait, $stable(out_data), "out beat changed")

    // The three beats of one field update are offered back to back; out_stall can still hold each one
    `THCLU_ASSERT_NEXT(a_update_burst, out_take && !out_data.last_write, out_valid, "update gap")

    `THCLU_ASSERT_SAME(a_cmd_form, out_cmd, out_data.lcd_byte[7] && !out_data.last_write, "bad cmd")

endmodule

bind twelve_hour_clock_lcd_updater_unit thclu_checker u_thclu_checker (.*);
